### rtl/polygon_capture_point_in_polygon_macros.svh
// ---------------------------------------------------------------------------
// polygon capture assertion macros
// shared assertion helpers for the polygon capture block
// ---------------------------------------------------------------------------
`ifndef POLYGON_CAPTURE_POINT_IN_POLYGON_MACROS_SVH
`define POLYGON_CAPTURE_POINT_IN_POLYGON_MACROS_SVH

// same-cycle implication, checked out of reset
`define PCPIP_AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcpip assertion failed");

// next-cycle implication, checked out of reset
`define PCPIP_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcpip assertion failed");

`endif

### rtl/pcpip_pkg.sv
// ---------------------------------------------------------------------------
// pcpip_pkg
// constants and codes of the polygon capture block
// ---------------------------------------------------------------------------
package pcpip_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 16;
  localparam int TAG_W        = 8;
  localparam int PROX_W       = 16;
  localparam logic [PROX_W-1:0] PROX_RESET = 16'd51;

  typedef enum logic [2:0] {
    ST_STARTED     = 3'd0,
    ST_ADDED       = 3'd1,
    ST_FRAME_RESET = 3'd2,
    ST_TOO_FEW     = 3'd3,
    ST_CLOSED      = 3'd4,
    ST_OUTSIDE     = 3'd5,
    ST_ACCEPTED    = 3'd6,
    ST_FULL        = 3'd7
  } status_t;

endpackage

### rtl/pcpip_ram.sv
// ---------------------------------------------------------------------------
// pcpip_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module pcpip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/polygon_capture_point_in_polygon.sv
// ---------------------------------------------------------------------------
// polygon_capture_point_in_polygon
// builds a polygon from clicked points and runs a crossing-number test on
// the center point once the polygon is closed
// ---------------------------------------------------------------------------
// channel  | dir | contents
// in_      | in  | tdata {point_y, point_x}, tuser frame_tag
// out_     | out | tdata {awaiting_center, vertex_count, status}
// cfg_     | in  | proximity write
//
// start, frame reset and append go through the decide and done states, the
//   closing test adds two near states, and a center test reads the ram and
//   multiplies once per edge
// each edge takes a multiply state and a compare state
// reset: synchronous active low, clears the vertex count and flags and
//   restores proximity to 51
// a new item is taken while a result still waits; the block stalls only when
//   a second result is ready before the first has been taken
// ---------------------------------------------------------------------------
`include "polygon_capture_point_in_polygon_macros.svh"

module polygon_capture_point_in_polygon (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // point_x [15:0], point_y [31:16]
  input  logic [7:0]  in_tuser,   // frame_tag [7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status [2:0], vertex_count [8:3],
                                  // awaiting_center [9], zero [15:10]
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int CW = pcpip_pkg::COORD_W;
  localparam int VW = pcpip_pkg::VIDX_W;
  localparam int NW = pcpip_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_NEAR1, S_NEAR2, S_CPRIME, S_CMUL, S_CCMP, S_DONE
  } state_t;

  state_t state_r;

  // control state
  logic [NW-1:0]                  total_r;
  logic                           pending_r;
  logic [pcpip_pkg::TAG_W-1:0]    frame_r;
  logic [pcpip_pkg::PROX_W-1:0]   prox_r;
  logic [NW-1:0]                  idx_r;
  logic                           parity_r;
  logic                           out_tvalid_r;
  logic [15:0]                    out_tdata_r;

  // payload
  logic signed [CW-1:0]           px_r, py_r, first_x_r, first_y_r;
  logic [pcpip_pkg::TAG_W-1:0]    tag_r;
  logic signed [CW-1:0]           xj_r, yj_r;
  logic signed [2*CW+1:0]         lhs_r, rhs_r;
  logic                           cond_r, dir_r;
  logic [2*CW+1:0]                dx2_r, dy2_r;
  logic [2*pcpip_pkg::PROX_W-1:0] r2_r;
  pcpip_pkg::status_t             res_status_r;

  // vertex ram, entry packed as {y, x}
  logic            ram_we, ram_re;
  logic [VW-1:0]   ram_waddr, ram_raddr;
  logic [2*CW-1:0] ram_wdata, ram_rdata;
  logic signed [CW-1:0] xi, yi;

  pcpip_ram #(
    .WIDTH(2 * CW),
    .DEPTH(pcpip_pkg::MAX_VERTICES)
  ) u_vtx_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign xi = ram_rdata[CW-1:0];
  assign yi = ram_rdata[2*CW-1:CW];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // append decision shared by the direct and the post-closing-test paths
  logic can_append;
  assign can_append = (total_r < NW'(pcpip_pkg::MAX_VERTICES));

  // ram port drive
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = total_r[VW-1:0];
    ram_wdata = {py_r, px_r};
    ram_re    = 1'b0;
    ram_raddr = idx_r[VW-1:0];
    unique case (state_r)
      S_DECIDE: begin
        if (pending_r) begin
          ram_re    = 1'b1;
          ram_raddr = VW'(total_r - NW'(1));
        end else if (total_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else if (frame_r == tag_r) begin
          ram_we = (total_r == NW'(1)) && can_append;
        end
      end
      S_NEAR2: begin
        ram_we = !({1'b0, dx2_r} + {1'b0, dy2_r} < (2*CW+3)'(r2_r)) && can_append;
      end
      S_CPRIME: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_CCMP: begin
        ram_re    = 1'b1;
        ram_raddr = VW'(idx_r + NW'(1));
      end
      default: ;
    endcase
  end

  // edge arithmetic, operands widened by one bit so differences are exact
  logic signed [CW:0] e_dx, e_dy, e_ex, e_ey;
  assign e_dx = {px_r[CW-1], px_r} - {xi[CW-1], xi};
  assign e_dy = {yj_r[CW-1], yj_r} - {yi[CW-1], yi};
  assign e_ex = {xj_r[CW-1], xj_r} - {xi[CW-1], xi};
  assign e_ey = {py_r[CW-1], py_r} - {yi[CW-1], yi};

  logic signed [CW:0] n_dx, n_dy;
  assign n_dx = {first_x_r[CW-1], first_x_r} - {px_r[CW-1], px_r};
  assign n_dy = {first_y_r[CW-1], first_y_r} - {py_r[CW-1], py_r};

  // full-width squares of the distance to the first vertex
  logic signed [2*CW+1:0] n_dx2, n_dy2;
  assign n_dx2 = n_dx * n_dx;
  assign n_dy2 = n_dy * n_dy;

  logic hit;
  assign hit = dir_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      pending_r    <= 1'b0;
      frame_r      <= '0;
      prox_r       <= pcpip_pkg::PROX_RESET;
      idx_r        <= '0;
      parity_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        prox_r <= cfg_wr_data;
      end
      // the done state reloads the result register itself
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            px_r    <= in_tdata[CW-1:0];
            py_r    <= in_tdata[2*CW-1:CW];
            tag_r   <= in_tuser;
            state_r <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          priority if (pending_r) begin
            // read of the last vertex is under way
            state_r <= S_CPRIME;
          end else if (total_r == '0) begin
            first_x_r    <= px_r;
            first_y_r    <= py_r;
            total_r      <= NW'(1);
            frame_r      <= tag_r;
            res_status_r <= pcpip_pkg::ST_STARTED;
            state_r      <= S_DONE;
          end else if (frame_r != tag_r) begin
            total_r      <= '0;
            res_status_r <= pcpip_pkg::ST_FRAME_RESET;
            state_r      <= S_DONE;
          end else if (total_r > NW'(1)) begin
            state_r <= S_NEAR1;
          end else begin
            // one vertex held: closing is not tested
            if (can_append) begin
              total_r      <= total_r + NW'(1);
              res_status_r <= pcpip_pkg::ST_ADDED;
            end else begin
              res_status_r <= pcpip_pkg::ST_FULL;
            end
            state_r <= S_DONE;
          end
        end

        S_NEAR1: begin
          dx2_r   <= n_dx2;
          dy2_r   <= n_dy2;
          r2_r    <= prox_r * prox_r;
          state_r <= S_NEAR2;
        end

        S_NEAR2: begin
          if ({1'b0, dx2_r} + {1'b0, dy2_r} < (2*CW+3)'(r2_r)) begin
            if (total_r < NW'(3)) begin
              total_r      <= '0;
              res_status_r <= pcpip_pkg::ST_TOO_FEW;
            end else begin
              pending_r    <= 1'b1;
              res_status_r <= pcpip_pkg::ST_CLOSED;
            end
          end else if (can_append) begin
            total_r      <= total_r + NW'(1);
            res_status_r <= pcpip_pkg::ST_ADDED;
          end else begin
            res_status_r <= pcpip_pkg::ST_FULL;
          end
          state_r <= S_DONE;
        end

        S_CPRIME: begin
          // last vertex is edge start for vertex 0
          xj_r     <= xi;
          yj_r     <= yi;
          idx_r    <= '0;
          parity_r <= 1'b0;
          state_r  <= S_CMUL;
        end

        S_CMUL: begin
          cond_r  <= (yi > py_r) != (yj_r > py_r);
          dir_r   <= e_dy > 0;
          lhs_r   <= e_dx * e_dy;
          rhs_r   <= e_ex * e_ey;
          xj_r    <= xi;
          yj_r    <= yi;
          state_r <= S_CCMP;
        end

        S_CCMP: begin
          if (idx_r + NW'(1) == total_r) begin
            res_status_r <= (parity_r ^ (cond_r && hit)) ? pcpip_pkg::ST_ACCEPTED
                                                          : pcpip_pkg::ST_OUTSIDE;
            pending_r    <= 1'b0;
            total_r      <= '0;
            state_r      <= S_DONE;
          end else begin
            parity_r <= parity_r ^ (cond_r && hit);
            idx_r    <= idx_r + NW'(1);
            state_r  <= S_CMUL;
          end
        end

        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {6'd0, pending_r, 6'(total_r), res_status_r};
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PCPIP_AST_IMPL(a_pending_has_polygon, pending_r, total_r >= NW'(3))
  `PCPIP_AST_IMPL(a_total_bounded, 1'b1, total_r <= NW'(pcpip_pkg::MAX_VERTICES))
  `PCPIP_AST_NEXT(a_result_from_done, state_r == S_DONE && (!out_tvalid_r || out_tready), out_tvalid_r && state_r == S_IDLE)

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the polygon capture block: clicked points go in on
// the input stream, an in-bench model of the vertex store and the crossing
// test predicts each status item, and the output stream is compared with it
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one clicked point
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         tag;
  } click_t;

  // one status item as the block reports it
  typedef struct {
    pcpip_pkg::status_t status;
    logic [5:0]         count;
    logic               awaiting;
  } report_t;

  // a directed row: point plus optional typed expectation
  typedef struct {
    click_t  pt;
    bit      typed;
    report_t rep;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // point_x [15:0], point_y [31:16]
  logic [7:0]  in_tuser;   // frame_tag [7:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // status [2:0], vertex_count [8:3], awaiting_center [9]
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  polygon_capture_point_in_polygon dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // ---- shadow copy of the block state ----
  logic signed [15:0] poly_x [pcpip_pkg::MAX_VERTICES];
  logic signed [15:0] poly_y [pcpip_pkg::MAX_VERTICES];
  int unsigned        poly_total;
  bit                 center_wait;
  logic [7:0]         poly_frame;
  logic [15:0]        radius;

  report_t     pending_reports [$];
  bit          typed_next;       // next accepted item carries a typed expectation
  report_t     typed_rep;
  int          errors;
  int          items_in;
  int          items_out;
  int          status_seen [8];
  int          idle_cycles;
  bit          hold_done;

  // squared distance to the first vertex against the squared radius
  function automatic bit near_start(longint px, longint py);
    longint dx, dy;
    dx = longint'(poly_x[0]) - px;
    dy = longint'(poly_y[0]) - py;
    return (dx * dx + dy * dy) < (longint'(radius) * longint'(radius));
  endfunction

  // crossing count over all edges, cross-multiplied to avoid the division
  function automatic bit center_inside(longint px, longint py);
    int     hits;
    int     j;
    longint xi, yi, xj, yj, dy, lhs, rhs;
    hits = 0;
    if (poly_total == 0) return 1'b0;
    j = poly_total - 1;
    for (int i = 0; i < poly_total; i++) begin
      xi = poly_x[i]; yi = poly_y[i];
      xj = poly_x[j]; yj = poly_y[j];
      if ((yi > py) != (yj > py)) begin
        dy  = yj - yi;
        lhs = (px - xi) * dy;
        rhs = (xj - xi) * (py - yi);
        if (dy > 0 ? (lhs < rhs) : (lhs > rhs)) hits++;
      end
      j = i;
    end
    return hits[0];
  endfunction

  // advance the shadow state by one point and return the status item
  function automatic report_t capture_step(click_t c);
    report_t r;
    if (center_wait) begin
      r.status    = center_inside(c.x, c.y) ? pcpip_pkg::ST_ACCEPTED
                                            : pcpip_pkg::ST_OUTSIDE;
      center_wait = 1'b0;
      poly_total  = 0;
    end else if (poly_total == 0) begin
      poly_x[0]  = c.x;
      poly_y[0]  = c.y;
      poly_total = 1;
      poly_frame = c.tag;
      r.status   = pcpip_pkg::ST_STARTED;
    end else if (poly_frame != c.tag) begin
      poly_total = 0;
      r.status   = pcpip_pkg::ST_FRAME_RESET;
    end else if (poly_total > 1 && near_start(c.x, c.y)) begin
      if (poly_total < 3) begin
        poly_total = 0;
        r.status   = pcpip_pkg::ST_TOO_FEW;
      end else begin
        center_wait = 1'b1;
        r.status    = pcpip_pkg::ST_CLOSED;
      end
    end else if (poly_total >= pcpip_pkg::MAX_VERTICES) begin
      r.status = pcpip_pkg::ST_FULL;
    end else begin
      poly_x[poly_total] = c.x;
      poly_y[poly_total] = c.y;
      poly_total++;
      r.status = pcpip_pkg::ST_ADDED;
    end
    r.count    = poly_total[5:0];
    r.awaiting = center_wait;
    return r;
  endfunction

  // ---- input side: predict on every accepted item ----
  always @(posedge clk) begin
    click_t  c;
    report_t r;
    if (rst_n && in_tvalid && in_tready) begin
      c.x   = in_tdata[15:0];
      c.y   = in_tdata[31:16];
      c.tag = in_tuser;
      r     = capture_step(c);
      // typed rows use the hand-written expectation, the model still advances
      if (typed_next) r = typed_rep;
      pending_reports.insert(pending_reports.size(), r);
      items_in++;
    end
  end

  // ---- output side: compare with the oldest expectation ----
  always @(posedge clk) begin
    report_t e;
    if (rst_n && out_tvalid && out_tready) begin
      items_out++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected item out_tdata=%h", $realtime, out_tdata);
        errors++;
      end else begin
        e = pending_reports.pop_front();
        status_seen[out_tdata[2:0]]++;
        if (out_tdata[2:0] !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, e.status,
                   out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[8:3] !== e.count) begin
          $display("%0t: vertex_count expected %0d actual %0d", $realtime, e.count,
                   out_tdata[8:3]);
          errors++;
        end
        if (out_tdata[9] !== e.awaiting) begin
          $display("%0t: awaiting_center expected %0d actual %0d", $realtime,
                   e.awaiting, out_tdata[9]);
          errors++;
        end
      end
    end
  end

  // ---- watchdog: cycles with nothing accepted on either side ----
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 6000) begin
      $display("watchdog expired at %0t", $realtime);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---- receiver: random stalls, one long hold-off to fill the block ----
  initial begin
    int run;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!hold_done && items_in >= 300) begin
        // long hold-off while the sender keeps offering items
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_done = 1'b1;
      end
      run = $urandom_range(0, 99);
      if (run < 60) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else if (run < 95) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(20, 120)) @(posedge clk);
      end
    end
  end

  // ---- sender ----
  task automatic send_point(click_t c, bit typed, report_t rep);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap  = pick < 55 ? 0 : pick < 92 ? $urandom_range(1, 3) : $urandom_range(10, 80);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= {c.y, c.x};
    in_tuser   <= c.tag;
    typed_next <= typed;
    typed_rep  <= rep;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // write the closing radius once the block has drained
  task automatic set_radius(logic [15:0] value);
    in_tvalid <= 1'b0;
    wait (pending_reports.size() == 0);
    // every result taken: the block is idle, leave a quiet margin anyway
    repeat (80) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    radius = value;
  endtask

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] in_box(int span);
    return clamp16(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // one well-formed capture with random content, sometimes broken
  task automatic queue_polygon(ref click_t plan [$]);
    click_t c, first;
    int     span, n, off, pick;
    pick = $urandom_range(0, 9);
    span = pick < 2 ? 32767 : $urandom_range(100, 3000);
    n    = pick == 9 ? $urandom_range(30, 34) : pick == 8 ? $urandom_range(1, 2)
         : $urandom_range(3, 8);
    first.tag = $urandom_range(0, 255);
    first.x   = in_box(span);
    first.y   = in_box(span);
    plan.insert(plan.size(), first);
    for (int k = 1; k < n; k++) begin
      c = first;
      if ($urandom_range(0, 24) == 0) c.tag = $urandom_range(0, 255);  // frame noise
      c.x = in_box(span);
      c.y = in_box(span);
      plan.insert(plan.size(), c);
    end
    // closing click near the first vertex
    off = radius > 2 ? $urandom_range(0, (radius > 2000 ? 2000 : radius) / 2) : 0;
    c = first;
    c.x = clamp16(int'(first.x) + off - int'($urandom_range(0, off)));
    c.y = clamp16(int'(first.y) - off / 2);
    plan.insert(plan.size(), c);
    // center click, any frame
    c.tag = $urandom_range(0, 255);
    c.x   = in_box(span);
    c.y   = in_box(span);
    plan.insert(plan.size(), c);
  endtask

  // directed rows at reset radius 51
  row_t directed [] = '{
    // start, add, then a click near the first with two held: too few
    '{'{16'sd0, 16'sd0, 8'd1}, 1, '{pcpip_pkg::ST_STARTED, 6'd1, 1'b0}},
    '{'{16'sd1000, 16'sd0, 8'd1}, 1, '{pcpip_pkg::ST_ADDED, 6'd2, 1'b0}},
    '{'{16'sd10, 16'sd10, 8'd1}, 1, '{pcpip_pkg::ST_TOO_FEW, 6'd0, 1'b0}},
    // one vertex held: nearby click is appended, then a frame change clears
    '{'{-16'sd32768, -16'sd32768, 8'd255}, 1, '{pcpip_pkg::ST_STARTED, 6'd1, 1'b0}},
    '{'{-16'sd32760, -16'sd32760, 8'd255}, 1, '{pcpip_pkg::ST_ADDED, 6'd2, 1'b0}},
    '{'{16'sd5, 16'sd5, 8'd7}, 1, '{pcpip_pkg::ST_FRAME_RESET, 6'd0, 1'b0}},
    // full-range square, closed, center in another frame
    '{'{16'sd32767, 16'sd32767, 8'd3}, 1, '{pcpip_pkg::ST_STARTED, 6'd1, 1'b0}},
    '{'{16'sd32767, -16'sd32768, 8'd3}, 1, '{pcpip_pkg::ST_ADDED, 6'd2, 1'b0}},
    '{'{-16'sd32768, -16'sd32768, 8'd3}, 1, '{pcpip_pkg::ST_ADDED, 6'd3, 1'b0}},
    '{'{-16'sd32768, 16'sd32767, 8'd3}, 1, '{pcpip_pkg::ST_ADDED, 6'd4, 1'b0}},
    '{'{16'sd32767, 16'sd32767, 8'd3}, 1, '{pcpip_pkg::ST_CLOSED, 6'd4, 1'b1}},
    '{'{16'sd0, 16'sd0, 8'd9}, 1, '{pcpip_pkg::ST_ACCEPTED, 6'd0, 1'b0}},
    // triangle with center outside, center on a vertex
    '{'{16'sd0, 16'sd0, 8'd2}, 1, '{pcpip_pkg::ST_STARTED, 6'd1, 1'b0}},
    '{'{16'sd256, 16'sd0, 8'd2}, 0, '{pcpip_pkg::ST_STARTED, 6'd0, 1'b0}},
    '{'{16'sd256, 16'sd256, 8'd2}, 0, '{pcpip_pkg::ST_STARTED, 6'd0, 1'b0}},
    '{'{16'sd0, 16'sd2, 8'd2}, 1, '{pcpip_pkg::ST_CLOSED, 6'd3, 1'b1}},
    '{'{16'sd1000, 16'sd1000, 8'd2}, 1, '{pcpip_pkg::ST_OUTSIDE, 6'd0, 1'b0}},
    '{'{16'sd0, 16'sd0, 8'd2}, 0, '{pcpip_pkg::ST_STARTED, 6'd0, 1'b0}},
    '{'{16'sd256, -16'sd256, 8'd2}, 0, '{pcpip_pkg::ST_STARTED, 6'd0, 1'b0}},
    '{'{-16'sd256, 16'sd256, 8'd2}, 0, '{pcpip_pkg::ST_STARTED, 6'd0, 1'b0}},
    '{'{16'sd20, 16'sd20, 8'd2}, 0, '{pcpip_pkg::ST_STARTED, 6'd0, 1'b0}},
    '{'{16'sd256, -16'sd256, 8'd2}, 0, '{pcpip_pkg::ST_STARTED, 6'd0, 1'b0}}
  };

  // radius settings taken in order by the first phases of the random part, extremes included
  logic [15:0] radius_plan [] = '{16'd0, 16'd65535, 16'd51, 16'd400, 16'd1,
                                  16'd3000, 16'd51};

  initial begin
    click_t plan [$];
    click_t stray;
    int     phase;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    typed_next  = 1'b0;
    errors      = 0;
    items_in    = 0;
    items_out   = 0;
    idle_cycles = 0;
    hold_done   = 1'b0;
    poly_total  = 0;
    center_wait = 1'b0;
    poly_frame  = '0;
    radius      = pcpip_pkg::PROX_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_point(directed[i].pt, directed[i].typed, directed[i].rep);

    // random captures in phases, one radius per phase
    phase = 0;
    while (items_in < 1600) begin
      set_radius(phase < radius_plan.size() ? radius_plan[phase]
                                            : 16'($urandom_range(0, 65535)));
      plan.delete();
      while (plan.size() < 180) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray click: random point and frame
          stray.x   = in_box(32767);
          stray.y   = in_box(32767);
          stray.tag = 8'($urandom_range(0, 255));
          plan.insert(plan.size(), stray);
        end else begin
          queue_polygon(plan);
        end
      end
      foreach (plan[k]) send_point(plan[k], 1'b0, typed_rep);
      phase++;
    end
    in_tvalid <= 1'b0;

    wait (pending_reports.size() == 0);
    repeat (100) @(posedge clk);
    $display("%0d points sent, %0d status items checked over %0d radius settings",
             items_in, items_out, phase + 1);
    $display("status mix: start %0d add %0d frame %0d few %0d close %0d out %0d in %0d full %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/pcpip_pkg.sv
rtl/pcpip_ram.sv
rtl/polygon_capture_point_in_polygon.sv
tb/tb_top.sv
